// ===== rtl/core/bti_pkg.sv =====
// ----------------------------------------------------------------------------
// bti_pkg
// Shared constants, codes and helpers for the breakpoint table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package bti_pkg;

    localparam int POINTS_DEFAULT = 64;

    // Operand widths of the shared arithmetic units
    localparam int MUL_W = 34;
    localparam int DIV_NW = 66;
    localparam int DIV_DW = 34;

    // pi with 32 fraction bits
    localparam logic [MUL_W-1:0] PI_Q32 = 34'h3243F6A89;
    // Offset magnitude clamp, 2^40
    localparam logic [DIV_NW-1:0] OFF_CLAMP = 66'h100_0000_0000;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FEW    = 2'd1;
    localparam logic [1:0] ST_BEYOND = 2'd2;

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        abs33 = v[32] ? (~v + 33'd1) : v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bti_mul.sv =====
// ----------------------------------------------------------------------------
// bti_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module bti_mul (
    input  wire logic                          clk,
    input  wire logic [bti_pkg::MUL_W-1:0]     a,
    input  wire logic [bti_pkg::MUL_W-1:0]     b,
    output logic      [2*bti_pkg::MUL_W-1:0]   p
);
    import bti_pkg::*;

    logic [2*MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== rtl/core/bti_div.sv =====
// ----------------------------------------------------------------------------
// bti_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bti_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [bti_pkg::DIV_NW-1:0]   num,
    input  wire logic [bti_pkg::DIV_DW-1:0]   den,
    output logic                              done,
    output logic      [bti_pkg::DIV_NW-1:0]   quo
);
    import bti_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] num_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DIV_DW:0]   rem2;
    logic              take;

    assign rem2 = {rem_reg, num_reg[DIV_NW-1]};
    assign take = (rem2 >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(DIV_NW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            // shift in next numerator bit, subtract when it fits
            rem_reg <= take ? DIV_DW'(rem2 - {1'b0, den_reg}) : rem2[DIV_DW-1:0];
            num_reg <= {num_reg[DIV_NW-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_NW-2:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/breakpoint_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator
// Piecewise linear lookup of radius, area and slope in a breakpoint table.
// ----------------------------------------------------------------------------
// A word with kind = write stores one breakpoint in the cycle it is accepted
// and returns no result; busy stays low. A word with kind = query raises busy
// and, when it drops, pulses done for one cycle with radius, area, slope and
// status. A full query scans the table through the single read port, up to
// point_count entries (at most POINTS), then fetches the segment end points,
// makes two passes of the shared bit-serial divider and four passes of the
// shared multiplier. A zero-length segment skips its divider pass. Too few
// points, and a query beyond the last position, go straight to the done state
// without the fetch and the arithmetic.
// The receiver cannot stall: take the result in the done cycle.
// Write point_count only while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none
module breakpoint_table_interpolator #(
    parameter int POINTS = bti_pkg::POINTS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               kind,
    input  wire logic [5:0]         point_index,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] query_x,
    input  wire logic               cfg_we,
    input  wire logic [6:0]         cfg_data,
    output logic                    done,
    output logic signed [31:0]      radius,
    output logic [62:0]             area,
    output logic signed [31:0]      slope,
    output logic [1:0]              status
);
    import bti_pkg::*;

    localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int CW = $clog2(POINTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_FETCH0, S_FETCH1, S_FETCH2, S_FETCH3,
        S_MUL_OFF, S_DIV_OFF_GO, S_DIV_OFF_WAIT, S_RADIUS, S_MUL_R2,
        S_MUL_A0, S_MUL_A1, S_AREA, S_DIV_SLP_GO, S_DIV_SLP_WAIT, S_DONE
    } state_t;

    // Breakpoint memories, one read port shared by scan and fetch
    logic signed [31:0] pos_mem [POINTS];
    logic signed [31:0] rad_mem [POINTS];
    logic signed [31:0] pos_rd_reg;
    logic signed [31:0] rad_rd_reg;
    logic [AW-1:0]      rd_addr;

    state_t             state_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [6:0]         count_reg;
    logic [CW-1:0]      n_reg;
    logic [AW-1:0]      i_reg;
    logic [AW-1:0]      idx_reg;
    logic               next_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] x1_reg, x2_reg, x3_reg;
    logic signed [31:0] y1_reg, y2_reg, y3_reg;
    logic [40:0]        off_reg;
    logic [63:0]        r2_reg;
    logic [97:0]        acc_reg;
    logic signed [31:0] radius_reg;
    logic [62:0]        area_reg;
    logic signed [31:0] slope_reg;
    logic [1:0]         status_reg;

    logic               accept;
    logic [CW-1:0]      n_eff;
    logic [CW-1:0]      i_ext;
    logic               scan_last;

    // Segment differences
    logic signed [32:0] u_d, dy_d, dx_d, dys_d, dxs_d;
    logic [32:0]        mu, my, md, mys, mds;
    logic               off_neg, slp_neg;
    logic [31:0]        r_abs;
    logic signed [42:0] r_sum;
    logic [97:0]        area_tot;

    // Shared unit hookups
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;
    logic               div_start;
    logic [DIV_NW-1:0]  div_num;
    logic [DIV_DW-1:0]  div_den;
    logic               div_done;
    logic [DIV_NW-1:0]  div_quo;

    assign accept = start && !busy_reg;

    assign n_eff = (32'(count_reg) > POINTS) ? CW'(POINTS) : CW'(count_reg);
    assign i_ext = CW'(i_reg);
    assign scan_last = (i_ext == n_reg - CW'(1));

    assign u_d   = 33'(q_reg)  - 33'(x1_reg);
    assign dy_d  = 33'(y2_reg) - 33'(y1_reg);
    assign dx_d  = 33'(x2_reg) - 33'(x1_reg);
    assign dys_d = next_reg ? (33'(y3_reg) - 33'(y1_reg)) : dy_d;
    assign dxs_d = next_reg ? (33'(x3_reg) - 33'(x1_reg)) : dx_d;
    assign mu  = abs33(u_d);
    assign my  = abs33(dy_d);
    assign md  = abs33(dx_d);
    assign mys = abs33(dys_d);
    assign mds = abs33(dxs_d);
    assign off_neg = u_d[32] ^ dy_d[32] ^ dx_d[32];
    assign slp_neg = dys_d[32] ^ dxs_d[32];

    assign r_abs = radius_reg[31] ? (~radius_reg + 32'd1) : radius_reg;
    assign r_sum = off_neg ? (43'(y1_reg) - 43'(off_reg)) : (43'(y1_reg) + 43'(off_reg));
    assign area_tot = acc_reg + {mul_p[65:0], 32'd0};

    // Read address: scan walks i, fetch reads around the found entry
    always_comb
    begin
        case (state_reg)
            S_FETCH0: rd_addr = idx_reg - AW'(1);
            S_FETCH1: rd_addr = idx_reg;
            S_FETCH2: rd_addr = idx_reg + AW'(1);
            default:  rd_addr = i_reg;
        endcase
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_MUL_OFF:
            begin
                mul_a = {1'b0, mu};
                mul_b = {1'b0, my};
            end
            S_MUL_R2:
            begin
                mul_a = {2'b00, r_abs};
                mul_b = {2'b00, r_abs};
            end
            S_MUL_A0:
            begin
                mul_a = {2'b00, mul_p[31:0]};
                mul_b = PI_Q32;
            end
            S_MUL_A1:
            begin
                mul_a = {2'b00, r2_reg[63:32]};
                mul_b = PI_Q32;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Operand select for the shared divider
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            S_DIV_OFF_GO:
            begin
                div_start = (dx_d != '0);
                div_num   = mul_p[DIV_NW-1:0];
                div_den   = {1'b0, md};
            end
            S_DIV_SLP_GO:
            begin
                div_start = (dxs_d != '0);
                div_num   = {17'd0, mys, 16'd0};
                div_den   = {1'b0, mds};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    bti_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    bti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Table storage: write on an accepted write word, read every cycle
    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_WRITE && 32'(point_index) < POINTS)
        begin
            pos_mem[AW'(point_index)] <= point_x;
            rad_mem[AW'(point_index)] <= point_y;
        end
        pos_rd_reg <= pos_mem[rd_addr];
        rad_rd_reg <= rad_mem[rd_addr];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            n_reg      <= '0;
            i_reg      <= '0;
            idx_reg    <= '0;
            next_reg   <= 1'b0;
            q_reg      <= '0;
            x1_reg     <= '0;
            x2_reg     <= '0;
            x3_reg     <= '0;
            y1_reg     <= '0;
            y2_reg     <= '0;
            y3_reg     <= '0;
            off_reg    <= '0;
            r2_reg     <= '0;
            acc_reg    <= '0;
            radius_reg <= '0;
            area_reg   <= '0;
            slope_reg  <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && kind == KIND_QUERY)
                    begin
                        busy_reg   <= 1'b1;
                        q_reg      <= query_x;
                        n_reg      <= n_eff;
                        i_reg      <= '0;
                        radius_reg <= '0;
                        area_reg   <= '0;
                        slope_reg  <= '0;
                        status_reg <= ST_OK;
                        if (n_eff < CW'(2))
                        begin
                            status_reg <= ST_FEW;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    if (pos_rd_reg > q_reg)
                    begin
                        // first segment covers queries at or below the start
                        idx_reg   <= (i_reg == '0) ? AW'(1) : i_reg;
                        next_reg  <= ((i_reg == '0) ? CW'(1) : i_ext) < n_reg - CW'(1);
                        state_reg <= S_FETCH0;
                    end
                    else if (scan_last)
                    begin
                        if (q_reg > pos_rd_reg)
                        begin
                            status_reg <= ST_BEYOND;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= i_reg;
                            next_reg  <= 1'b0;
                            state_reg <= S_FETCH0;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + AW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_FETCH0:
                begin
                    state_reg <= S_FETCH1;
                end
                S_FETCH1:
                begin
                    x1_reg    <= pos_rd_reg;
                    y1_reg    <= rad_rd_reg;
                    state_reg <= S_FETCH2;
                end
                S_FETCH2:
                begin
                    x2_reg    <= pos_rd_reg;
                    y2_reg    <= rad_rd_reg;
                    state_reg <= S_FETCH3;
                end
                S_FETCH3:
                begin
                    x3_reg    <= pos_rd_reg;
                    y3_reg    <= rad_rd_reg;
                    state_reg <= S_MUL_OFF;
                end
                S_MUL_OFF:
                begin
                    state_reg <= S_DIV_OFF_GO;
                end
                S_DIV_OFF_GO:
                begin
                    if (dx_d == '0)
                    begin
                        off_reg   <= '0;
                        state_reg <= S_RADIUS;
                    end
                    else
                    begin
                        state_reg <= S_DIV_OFF_WAIT;
                    end
                end
                S_DIV_OFF_WAIT:
                begin
                    if (div_done)
                    begin
                        off_reg   <= (div_quo > OFF_CLAMP) ? OFF_CLAMP[40:0] : div_quo[40:0];
                        state_reg <= S_RADIUS;
                    end
                end
                S_RADIUS:
                begin
                    if (r_sum > 43'sd2147483647)
                    begin
                        radius_reg <= 32'sh7FFFFFFF;
                    end
                    else if (r_sum < -43'sd2147483648)
                    begin
                        radius_reg <= 32'sh80000000;
                    end
                    else
                    begin
                        radius_reg <= r_sum[31:0];
                    end
                    state_reg <= S_MUL_R2;
                end
                S_MUL_R2:
                begin
                    state_reg <= S_MUL_A0;
                end
                S_MUL_A0:
                begin
                    r2_reg    <= mul_p[63:0];
                    state_reg <= S_MUL_A1;
                end
                S_MUL_A1:
                begin
                    acc_reg   <= {30'd0, mul_p};
                    state_reg <= S_AREA;
                end
                S_AREA:
                begin
                    area_reg  <= (area_tot[97:95] != 3'd0) ? {63{1'b1}} : area_tot[94:32];
                    state_reg <= S_DIV_SLP_GO;
                end
                S_DIV_SLP_GO:
                begin
                    if (dxs_d == '0)
                    begin
                        slope_reg <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DIV_SLP_WAIT;
                    end
                end
                S_DIV_SLP_WAIT:
                begin
                    if (div_done)
                    begin
                        if (!slp_neg)
                        begin
                            slope_reg <= (div_quo > 66'h7FFFFFFF) ? 32'sh7FFFFFFF
                                                                   : div_quo[31:0];
                        end
                        else
                        begin
                            slope_reg <= (div_quo > 66'h80000000) ? 32'sh80000000
                                                                   : (~div_quo[31:0] + 32'd1);
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // present the word for one cycle, reopen the input
                    done_reg  <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign radius = radius_reg;
    assign area   = area_reg;
    assign slope  = slope_reg;
    assign status = status_reg;

endmodule
`default_nettype wire

// ===== rtl/core/bti_checker.sv =====
// ----------------------------------------------------------------------------
// bti_checker
// Port-level checks on the interpolator's result strobe and busy flag.
// ----------------------------------------------------------------------------
`default_nettype none
module bti_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        kind,
    input wire logic        done,
    input wire logic [31:0] radius,
    input wire logic [62:0] area,
    input wire logic [31:0] slope,
    input wire logic [1:0]  status
);
    import bti_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_QUERY) |=> busy)
        else $error("query did not raise busy");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_WRITE) |=> (!busy && !done))
        else $error("write word started work");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |->
            (radius == '0 && area == '0 && slope == '0 &&
             (status == ST_FEW || status == ST_BEYOND)))
        else $error("error result carries data");

endmodule

bind breakpoint_table_interpolator bti_checker u_bti_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .kind   (kind),
    .done   (done),
    .radius (radius),
    .area   (area),
    .slope  (slope),
    .status (status)
);
`default_nettype wire

// ===== verif/breakpoint_table_interpolator_tb.sv =====
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator_tb
// Self-checking bench: fills breakpoint tables, sweeps point_count across its
// range and checks every query result against an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module breakpoint_table_interpolator_tb;
    import bti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NPTS  = 64;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] radius;
        logic [62:0] area;
        logic [31:0] slope;
        logic [1:0]  status;
    } lookup_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               kind = KIND_WRITE;
    logic [5:0]         point_index = '0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic signed [31:0] query_x = '0;
    logic               cfg_we = 1'b0;
    logic [6:0]         cfg_data = '0;
    logic               done;
    logic signed [31:0] radius;
    logic [62:0]        area;
    logic signed [31:0] slope;
    logic [1:0]         status;

    // Predictor state: mirror of the breakpoint store and the count register
    longint      pos_tab [NPTS];
    longint      rad_tab [NPTS];
    int unsigned point_cnt = 0;

    lookup_t     pending_lookups[$];
    int          mismatches = 0;
    bit          no_idle = 1'b0;

    breakpoint_table_interpolator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .point_index (point_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .query_x     (query_x),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .radius      (radius),
        .area        (area),
        .slope       (slope),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp_q16(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // dy/dx in Q16.16, truncated toward zero; a zero run gives a flat slope
    function automatic longint ratio_q16(input longint dy, input longint dx);
        if (dx == 0) return 0;
        return clamp_q16((dy * 65536) / dx);
    endfunction

    // Work out the answer to one query from the mirrored table
    function automatic lookup_t predict_lookup(input logic [31:0] qx);
        lookup_t      res;
        int           n;
        int           idx;
        bit           found;
        bit           neg;
        longint       q, x1, x2, y1, y2, dx, dy, u, off, r, sl;
        logic [127:0] mu, my, md, prod, quo;
        longint unsigned rr;
        res = '0;
        res.status = ST_OK;
        n = (point_cnt > NPTS) ? NPTS : point_cnt;
        if (n < 2)
        begin
            res.status = ST_FEW;
            return res;
        end
        q = longint'($signed(qx));
        idx = n - 1;
        found = 1'b0;
        for (int i = 0; i < n; i++)
            if (!found && pos_tab[i] > q)
            begin
                idx = i;
                found = 1'b1;
            end
        if (!found && q > pos_tab[n-1])
        begin
            res.status = ST_BEYOND;
            return res;
        end
        if (idx < 1)
            idx = 1;
        x1 = pos_tab[idx-1];
        x2 = pos_tab[idx];
        y1 = rad_tab[idx-1];
        y2 = rad_tab[idx];
        dx = x2 - x1;
        dy = y2 - y1;
        u  = q - x1;
        // Offset is exact |u*dy|/|dx|, clamped to 2^40 before the sign goes back
        off = 0;
        if (dx != 0)
        begin
            neg  = (u < 0) ^ (dy < 0) ^ (dx < 0);
            mu   = 128'(u < 0 ? -u : u);
            my   = 128'(dy < 0 ? -dy : dy);
            md   = 128'(dx < 0 ? -dx : dx);
            prod = mu * my;
            quo  = prod / md;
            if (quo > 128'(OFF_CLAMP))
                quo = 128'(OFF_CLAMP);
            off = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        end
        r = clamp_q16(y1 + off);
        rr = longint'(r * r);
        prod = 128'(rr) * 128'(PI_Q32);
        if (prod[127:64] >= 64'h8000_0000)
            res.area = '1;
        else
            res.area = prod[94:32];
        if (idx < n - 1)
            sl = ratio_q16(rad_tab[idx+1] - y1, pos_tab[idx+1] - x1);
        else
            sl = ratio_q16(dy, dx);
        res.radius = r[31:0];
        res.slope  = sl[31:0];
        return res;
    endfunction

    // Present one word, hold it until the block takes it, then update the mirror
    task automatic send_word(input logic k, input logic [5:0] idx, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] qx);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind        <= k;
        point_index <= idx;
        point_x     <= px;
        point_y     <= py;
        query_x     <= qx;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (k == KIND_WRITE)
        begin
            pos_tab[idx] = longint'($signed(px));
            rad_tab[idx] = longint'($signed(py));
        end
        else
            pending_lookups.insert(pending_lookups.size(), predict_lookup(qx));
    endtask

    task automatic write_point(input int idx, input longint x, input longint y);
        send_word(KIND_WRITE, 6'(idx), x[31:0], y[31:0], $urandom);
    endtask

    task automatic ask(input longint qx);
        send_word(KIND_QUERY, 6'($urandom), $urandom, $urandom, qx[31:0]);
    endtask

    // Drop start and let every outstanding query drain
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_point_count(input int v);
        wait_idle();
        cfg_data <= 7'(v);
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        point_cnt = v;
        @(posedge clk);
    endtask

    // Check each done pulse against the oldest pending prediction
    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing pending: r=%h a=%h s=%h st=%0d",
                             radius, area, slope, status);
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (want.radius !== radius || want.area !== area ||
                    want.slope !== slope || want.status !== status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp r=%h a=%h s=%h st=%0d, got r=%h a=%h s=%h st=%0d",
                                 want.radius, want.area, want.slope, want.status,
                                 radius, area, slope, status);
                end
            end
        end
    end

    // Too few points: empty count and a single point
    task automatic test_too_few();
        ask(0);
        write_point(0, 0, 32'sh0001_0000);
        set_point_count(1);
        ask(32'sh0000_8000);
    endtask

    // Small hand-made tables: extrapolation, end points, flat and reversed runs
    task automatic test_directed();
        write_point(1, 32'sh0001_0000, 32'sh0003_0000);
        write_point(2, 32'sh0002_0000, 32'sh0002_0000);
        write_point(3, 32'sh0004_0000, 32'sh0006_0000);
        write_point(4, 32'sh0004_0000, 32'sh0009_0000);  // repeated x at the end
        set_point_count(5);
        ask(-32'sh0003_0000);
        ask(0);
        ask(32'sh0000_8000);
        ask(32'sh0003_0000);
        ask(32'sh0004_0000);
        ask(32'sh0005_0000);
        ask(Q_MIN);
        ask(Q_MAX);
        // steep first segment: offset clamp and saturation
        write_point(0, 0, 0);
        write_point(1, 1, Q_MAX);
        set_point_count(2);
        ask(Q_MIN);
        ask(0);
        // descending positions
        write_point(0, 32'sh0005_0000, Q_MIN);
        write_point(1, 32'sh0002_0000, 32'sh0001_0000);
        write_point(2, -32'sh0001_0000, Q_MAX);
        set_point_count(3);
        ask(32'sh0003_0000);
        ask(-32'sh0004_0000);
    endtask

    // One phase: fresh ascending table under a chosen count, then mixed traffic
    task automatic run_phase(input int cnt, input int words);
        int     m;
        int     sc;
        int     i, j, t;
        longint x, a, b;
        m = (cnt > NPTS) ? NPTS : cnt;
        if (m < 2)
            m = 2;
        sc = $urandom_range(2, 26);
        x = longint'($signed($urandom)) >>> $urandom_range(1, 8);
        for (i = 0; i < m; i++)
        begin
            write_point(i, x, longint'($signed($urandom)) >>> $urandom_range(0, 31 - sc/2));
            x = x + (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1 << sc));
            if (x > Q_MAX)
                x = Q_MAX;
        end
        set_point_count(cnt);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int w = 0; w < words; w++)
        begin
            t = $urandom_range(0, 99);
            i = $urandom_range(0, m - 1);
            j = $urandom_range(0, m - 1);
            a = pos_tab[i];
            b = pos_tab[j];
            if (t < 10)
                write_point($urandom_range(0, NPTS - 1), longint'($signed($urandom)),
                            longint'($signed($urandom)));
            else if (t < 55)
                ask(a < b ? a + $urandom_range(0, 32'(b - a)) : b + $urandom_range(0, 32'(a - b)));
            else if (t < 70)
                ask(a);
            else if (t < 85)
                ask(longint'($signed($urandom)));
            else
                ask(clamp_q16(pos_tab[(t & 1) ? m - 1 : 0] +
                              longint'($urandom_range(0, 64)) - 32));
        end
    endtask

    task automatic test_random();
        int counts[12] = '{64, 2, 3, 127, 0, 1, 5, 9, 16, 33, 64, 100};
        foreach (counts[p])
            run_phase(counts[p], 20 + $urandom_range(0, 10));
        for (int p = 0; p < 6; p++)
            run_phase($urandom_range(2, 20), 30);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_too_few();
        test_directed();
        test_random();
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_lookups.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
